// ===== rtl/ccpp_pkg.sv =====
// Shared types and constants of the command/coordinate packet parser.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ccpp_pkg;

  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 2;
  localparam int COORD_W = 19;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W = 8;

  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 8'd1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h42;  // 'B'
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [BYTE_W-1:0] CHAR_LOWER_B = 8'h62;  // 'b'
  localparam logic [BYTE_W-1:0] CHAR_LOWER_C = 8'h63;  // 'c'
  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;  // '0'

  localparam logic [CNT_W-1:0] BODY_LEN    = 4'd9;
  localparam logic [CNT_W-1:0] COUNT_CLOSE = 4'd10;
  localparam logic [CNT_W-1:0] X_END       = 4'd4;   // positions 0..3 feed x
  localparam logic [CNT_W-1:0] Y_FIRST     = 4'd5;   // positions 5..8 feed y

  localparam logic [COORD_W-1:0] DECIMAL_BASE = 19'd10;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_BODY    = 2'd1,
    PH_TRAILER = 2'd2
  } phase_t;

  // Operation handed from the parser to the execution side.
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_CLEAR      = 3'd1,
    OP_CMD        = 3'd2,
    OP_DIGIT_X    = 3'd3,
    OP_DIGIT_Y    = 3'd4,
    OP_DONE       = 3'd5,
    OP_DONE_COORD = 3'd6
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/ccpp_front.sv =====
// Parser front end: framing state machine and configuration registers.
// Turns each received byte into one operation entry. Depends on ccpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccpp_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [ccpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ccpp_pkg::BYTE_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ccpp_pkg::BYTE_W-1:0]    rx_byte,
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output ccpp_pkg::entry_t                    push_entry
);
  import ccpp_pkg::*;

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  write_position, write_position_next;
  logic [CNT_W-1:0]  body_count, body_count_next;
  logic              closed_by_command, closed_by_command_next;
  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] tail_byte;
  logic              accept;
  logic              is_cmd;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign is_cmd     = (rx_byte == CHAR_LOWER_A) || (rx_byte == CHAR_LOWER_B) ||
                      (rx_byte == CHAR_LOWER_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      tail_byte   <= TAIL_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HEADER) begin
        header_byte <= cfg_data;
      end else if (cfg_index == REG_TAIL) begin
        tail_byte <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      write_position    <= '0;
      body_count        <= '0;
      closed_by_command <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      write_position    <= write_position_next;
      body_count        <= body_count_next;
      closed_by_command <= closed_by_command_next;
    end
  end

  always_comb begin
    phase_next             = phase;
    write_position_next    = write_position;
    body_count_next        = body_count;
    closed_by_command_next = closed_by_command;
    push_entry.op          = OP_NONE;
    push_entry.cmd         = '0;
    push_entry.data        = rx_byte;
    unique case (phase)
      PH_BODY: begin
        if (is_cmd) begin
          push_entry.op          = OP_CMD;
          push_entry.cmd         = CMD_W'(rx_byte - CHAR_LOWER_A + 8'd1);
          closed_by_command_next = 1'b1;
          phase_next             = PH_TRAILER;
        end else if (write_position < BODY_LEN) begin
          if (write_position < X_END) begin
            push_entry.op = OP_DIGIT_X;
          end else if (write_position >= Y_FIRST) begin
            push_entry.op = OP_DIGIT_Y;
          end
          write_position_next = write_position + 4'd1;
        end
        body_count_next = body_count + 4'd1;
        if (body_count_next == COUNT_CLOSE) begin
          phase_next = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        if (rx_byte == tail_byte) begin
          push_entry.op = (!closed_by_command && write_position == BODY_LEN) ?
                          OP_DONE_COORD : OP_DONE;
          phase_next    = PH_IDLE;
        end
      end
      default: begin
        // Idle, and the unused phase code, which behaves as idle.
        phase_next = PH_IDLE;
        if (rx_byte == header_byte) begin
          push_entry.op          = OP_CLEAR;
          phase_next             = PH_BODY;
          write_position_next    = '0;
          body_count_next        = 4'd1;
          closed_by_command_next = 1'b0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ccpp_queue.sv =====
// Two-entry queue between the parser front end and the execution back end.
// Holds ccpp_pkg::entry_t records. Depends on ccpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccpp_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  ccpp_pkg::entry_t  push_entry,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output ccpp_pkg::entry_t  pop_entry
);
  import ccpp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_QW-1:0] FULL_COUNT = CNT_QW'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_QW-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != FULL_COUNT);
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ccpp_back.sv =====
// Execution back end: decimal accumulators for x and y and the result register.
// Consumes one operation entry per result. Depends on ccpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccpp_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pop_valid,
  output logic                              pop_ready,
  input  ccpp_pkg::entry_t                  pop_entry,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ccpp_pkg::CMD_W-1:0]        command,
  output logic                              packet_done,
  output logic                              coords_valid,
  output logic signed [ccpp_pkg::COORD_W-1:0] coord_x,
  output logic signed [ccpp_pkg::COORD_W-1:0] coord_y
);
  import ccpp_pkg::*;

  logic signed [COORD_W-1:0] x_acc;
  logic signed [COORD_W-1:0] y_acc;
  logic signed [COORD_W-1:0] digit;
  logic                      take;

  assign pop_ready = !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;
  // Digit value is the byte minus the ASCII zero, kept signed.
  assign digit = $signed({{(COORD_W - BYTE_W){1'b0}}, pop_entry.data}) -
                 $signed({{(COORD_W - BYTE_W){1'b0}}, CHAR_ZERO});

  // Horner form: each new digit is added to ten times the running value.
  always_ff @(posedge clk) begin
    if (take) begin
      unique case (pop_entry.op)
        OP_CLEAR: begin
          x_acc <= '0;
          y_acc <= '0;
        end
        OP_DIGIT_X: x_acc <= COORD_W'(x_acc * $signed(DECIMAL_BASE)) + digit;
        OP_DIGIT_Y: y_acc <= COORD_W'(y_acc * $signed(DECIMAL_BASE)) + digit;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      command      <= (pop_entry.op == OP_CMD) ? pop_entry.cmd : '0;
      packet_done  <= (pop_entry.op == OP_DONE) || (pop_entry.op == OP_DONE_COORD);
      coords_valid <= (pop_entry.op == OP_DONE_COORD);
      coord_x      <= (pop_entry.op == OP_DONE_COORD) ? x_acc : '0;
      coord_y      <= (pop_entry.op == OP_DONE_COORD) ? y_acc : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/command_coordinate_packet_parser.sv =====
// Top level of the command/coordinate packet parser.
// Instantiates ccpp_front, ccpp_queue and ccpp_back; depends on ccpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// -------   -------------------   ----------------------------------------------
// input     in_valid / in_ready   rx_byte
// output    out_valid / out_ready command, packet_done, coords_valid, coord_x, coord_y
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every accepted byte produces exactly one result transfer, one byte per cycle sustained
// while out_ready stays high. A result is presented once its byte's operation has been
// written into the queue and then loaded into the output register of the back end.
// While a result is stalled the two-entry queue still takes up to two more bytes.
// Reset clears the framing state, the queue and the output valid, and loads header 'A' and
// tail 'B'. The configuration port is always ready and takes one write per cycle.

module command_coordinate_packet_parser (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [ccpp_pkg::BYTE_W-1:0]      rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [ccpp_pkg::CMD_W-1:0]            command,
  output logic                                  packet_done,
  output logic                                  coords_valid,
  output logic signed [ccpp_pkg::COORD_W-1:0]   coord_x,
  output logic signed [ccpp_pkg::COORD_W-1:0]   coord_y,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ccpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ccpp_pkg::BYTE_W-1:0]      cfg_data
);
  import ccpp_pkg::*;

  // Parser to queue.
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  // Queue to execution side.
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  // The front end tracks framing (idle, body, trailer), counts body bytes and decides
  // for every byte which operation the back end must run.
  ccpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // The queue decouples the two sides so either one can stall on its own.
  ccpp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // The back end accumulates the decimal coordinates digit by digit and registers the
  // result of each operation on the output channel.
  ccpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .command      (command),
    .packet_done  (packet_done),
    .coords_valid (coords_valid),
    .coord_x      (coord_x),
    .coord_y      (coord_y)
  );

  // Coordinates are only ever reported together with the end of a packet.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && coords_valid |-> packet_done)
    else $error("coords_valid without packet_done");

  // Coordinates read as zero when they are not reported.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !coords_valid |-> (coord_x == '0) && (coord_y == '0))
    else $error("nonzero coordinates without coords_valid");

  // A command letter is only seen in the body, never on the tail byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (command != '0) |-> !packet_done)
    else $error("command and packet_done in one result");

  // An operation taken from the queue while the output is free shows up as a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready |=> out_valid)
    else $error("accepted operation produced no result");

endmodule

`default_nettype wire
